@@ hdl/bdp_pkg.sv @@
// Package for the button double-press command decoder.
// Holds the command, gesture-state and result types, lever positions, output codes and code mapping.
// No dependencies; every other file of the block but the checker imports it.
package bdp_pkg;

    // Internal command encoding, as carried in the pending and last command registers.
    typedef enum logic [3:0] {
        CMD_UNKNOWN    = 4'd0,
        CMD_NONE       = 4'd1,
        CMD_LEFT       = 4'd2,
        CMD_RIGHT      = 4'd3,
        CMD_SPEED_UP   = 4'd4,
        CMD_SPEED_DOWN = 4'd5,
        CMD_GAP_UP     = 4'd6,
        CMD_GAP_DOWN   = 4'd7,
        CMD_RESET      = 4'd8
    } t_cmd;

    // Gesture tracking states.
    typedef enum logic [2:0] {
        ST_UNKNOWN  = 3'd0,
        ST_READY    = 3'd1,
        ST_WAIT     = 3'd2,
        ST_RELEASED = 3'd3,
        ST_EXECUTE  = 3'd4
    } t_gesture_state;

    // Output command codes.
    localparam logic [2:0] CODE_LEFT_LANE  = 3'd0;
    localparam logic [2:0] CODE_RIGHT_LANE = 3'd1;
    localparam logic [2:0] CODE_SPEED_UP   = 3'd2;
    localparam logic [2:0] CODE_SPEED_DOWN = 3'd3;
    localparam logic [2:0] CODE_GAP_UP     = 3'd4;
    localparam logic [2:0] CODE_GAP_DOWN   = 3'd5;
    localparam logic [2:0] CODE_RESET      = 3'd6;

    // Turn lever positions.
    localparam logic [1:0] TURN_LEFT  = 2'd1;
    localparam logic [1:0] TURN_RIGHT = 2'd2;

    // Result of one processed report, handed from the gesture core to the top level.
    typedef struct packed {
        logic       emit;
        logic [2:0] code;
    } t_result;

    function automatic logic [2:0] output_code(input t_cmd cmd);
        logic [2:0] code;
        case (cmd)
            CMD_LEFT:       code = CODE_LEFT_LANE;
            CMD_RIGHT:      code = CODE_RIGHT_LANE;
            CMD_SPEED_UP:   code = CODE_SPEED_UP;
            CMD_SPEED_DOWN: code = CODE_SPEED_DOWN;
            CMD_GAP_UP:     code = CODE_GAP_UP;
            CMD_GAP_DOWN:   code = CODE_GAP_DOWN;
            CMD_RESET:      code = CODE_RESET;
            default:        code = CODE_LEFT_LANE;
        endcase
        return code;
    endfunction

endpackage

@@ hdl/bdp_decode.sv @@
// Control report decoder: turns the lever position and five buttons into one command.
// Depends on bdp_pkg for the command type and the lever positions.
module bdp_decode (
    input  logic [1:0]   i_lever_pos,
    input  logic         i_gap_decrease_button,
    input  logic         i_gap_increase_button,
    input  logic         i_accel_button,
    input  logic         i_decel_button,
    input  logic         i_resume_button,
    output bdp_pkg::t_cmd o_cmd
);
    import bdp_pkg::*;

    logic       w_left;
    logic       w_right;
    logic [2:0] w_count;
    t_cmd       w_single;

    assign w_left  = (i_lever_pos == TURN_LEFT);
    assign w_right = (i_lever_pos == TURN_RIGHT);

    assign w_count = 3'(w_left) + 3'(w_right) + 3'(i_gap_decrease_button)
                   + 3'(i_gap_increase_button) + 3'(i_accel_button)
                   + 3'(i_decel_button) + 3'(i_resume_button);

    // Only consulted when exactly one control is active.
    always_comb begin
        if (i_resume_button) begin
            w_single = CMD_RESET;
        end else if (i_decel_button) begin
            w_single = CMD_SPEED_DOWN;
        end else if (i_accel_button) begin
            w_single = CMD_SPEED_UP;
        end else if (i_gap_increase_button) begin
            w_single = CMD_GAP_UP;
        end else if (i_gap_decrease_button) begin
            w_single = CMD_GAP_DOWN;
        end else if (w_right) begin
            w_single = CMD_RIGHT;
        end else begin
            w_single = CMD_LEFT;
        end
    end

    always_comb begin
        if (w_count == 3'd0) begin
            o_cmd = CMD_NONE;
        end else if (w_count == 3'd1) begin
            o_cmd = w_single;
        end else begin
            o_cmd = CMD_UNKNOWN;
        end
    end

endmodule

@@ hdl/bdp_gesture.sv @@
// Gesture state machine and command counter for the double-press decoder.
// Depends on bdp_pkg for the command and state types and the code mapping.
module bdp_gesture (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_advance,
    input  bdp_pkg::t_cmd    i_cmd,
    output bdp_pkg::t_result o_result,
    output logic [31:0]      o_sequence_number
);
    import bdp_pkg::*;

    t_gesture_state r_state, n_state, w_trans;
    t_cmd           r_pending, n_pending;
    t_cmd           r_last, n_last;
    logic           r_nsp, n_nsp;
    logic [31:0]    r_count, n_count;
    logic           w_nsp_upd;
    logic           w_take;
    logic           w_clear;

    // Second-press flag tracks single-control reports, repeats too; clears set it.
    always_comb begin
        if (i_cmd == CMD_LEFT || i_cmd == CMD_RIGHT) begin
            w_nsp_upd = 1'b0;
        end else if (i_cmd >= CMD_SPEED_UP) begin
            w_nsp_upd = 1'b1;
        end else begin
            w_nsp_upd = r_nsp;
        end
    end

    always_comb begin
        case (r_state)
            ST_UNKNOWN:  w_trans = (i_cmd == CMD_NONE) ? ST_READY : ST_UNKNOWN;
            ST_READY:    w_trans = w_nsp_upd ? ST_WAIT : ST_EXECUTE;
            ST_WAIT:     w_trans = (i_cmd == CMD_NONE) ? ST_RELEASED : ST_UNKNOWN;
            ST_RELEASED: w_trans = (i_cmd == r_pending) ? ST_EXECUTE : ST_UNKNOWN;
            ST_EXECUTE: begin
                if (i_cmd == CMD_NONE) begin
                    w_trans = w_nsp_upd ? ST_RELEASED : ST_READY;
                end else begin
                    w_trans = ST_UNKNOWN;
                end
            end
            default:     w_trans = ST_UNKNOWN;
        endcase
    end

    assign w_take  = i_advance && (r_last != i_cmd);
    assign w_clear = w_take && (i_cmd == CMD_UNKNOWN || w_trans == ST_UNKNOWN);

    // Next state.
    always_comb begin
        if (w_clear) begin
            n_state = ST_UNKNOWN;
        end else if (w_take) begin
            n_state = w_trans;
        end else begin
            n_state = r_state;
        end
    end

    // Other register updates and the result.
    always_comb begin
        n_nsp     = r_nsp;
        n_last    = r_last;
        n_pending = r_pending;
        n_count   = r_count;
        o_result.emit = 1'b0;
        o_result.code = output_code((r_state == ST_READY) ? i_cmd : r_pending);
        if (i_advance) begin
            n_nsp = w_nsp_upd;
        end
        if (w_clear) begin
            n_nsp     = 1'b1;
            n_last    = CMD_UNKNOWN;
            n_pending = CMD_UNKNOWN;
        end else if (w_take) begin
            n_last = i_cmd;
            if (r_state == ST_READY) begin
                n_pending = i_cmd;
            end
            if (w_trans == ST_EXECUTE) begin
                o_result.emit = 1'b1;
                n_count       = r_count + 32'd1;
            end
        end
    end

    assign o_sequence_number = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_UNKNOWN;
            r_pending <= CMD_UNKNOWN;
            r_last    <= CMD_UNKNOWN;
            r_nsp     <= 1'b1;
            r_count   <= 32'd0;
        end else begin
            r_state   <= n_state;
            r_pending <= n_pending;
            r_last    <= n_last;
            r_nsp     <= n_nsp;
            r_count   <= n_count;
        end
    end

endmodule

@@ hdl/button_double_press_command_fsm.sv @@
// Top level of the button double-press command decoder.
// A request accepted into the input register shows its command, if any, on the
// outputs once it has advanced into the result register.
// Throughput: one request per cycle; the input register advances whenever the result
// register is empty or being taken, so the result register sets the pace.
// Reset (synchronous, active low) clears the gesture state, both valid flags and the
// sequence counter.
module button_double_press_command_fsm (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_lever_pos,
    input  logic        i_gap_decrease_button,
    input  logic        i_gap_increase_button,
    input  logic        i_accel_button,
    input  logic        i_decel_button,
    input  logic        i_resume_button,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_command_code,
    output logic [31:0] o_sequence_number
);
    import bdp_pkg::*;

    // Input register: holds one request for the decode and state update stage.
    logic        r_in_valid;
    logic [1:0]  r_lever_pos;
    logic        r_gap_decrease_button;
    logic        r_gap_increase_button;
    logic        r_accel_button;
    logic        r_decel_button;
    logic        r_resume_button;

    // Result register: holds one command until the downstream side takes it.
    logic        r_out_valid;
    logic [2:0]  r_command_code;
    logic [31:0] r_sequence_number;

    logic        w_advance;
    logic        w_in_take;
    t_cmd        w_cmd;
    t_result     w_result;
    logic [31:0] w_seq;

    // The held request is processed in the cycle the result register can absorb a
    // possible command: either it is empty or its command leaves at this edge.
    assign w_advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready   = !r_in_valid || w_advance;
    assign w_in_take = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_lever_pos           <= i_lever_pos;
            r_gap_decrease_button <= i_gap_decrease_button;
            r_gap_increase_button <= i_gap_increase_button;
            r_accel_button        <= i_accel_button;
            r_decel_button        <= i_decel_button;
            r_resume_button       <= i_resume_button;
        end
    end

    bdp_decode u_decode (
        .i_lever_pos           (r_lever_pos),
        .i_gap_decrease_button (r_gap_decrease_button),
        .i_gap_increase_button (r_gap_increase_button),
        .i_accel_button        (r_accel_button),
        .i_decel_button        (r_decel_button),
        .i_resume_button       (r_resume_button),
        .o_cmd                 (w_cmd)
    );

    // The gesture core updates its state only on a cycle the request advances.
    bdp_gesture u_gesture (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_advance         (w_advance),
        .i_cmd             (w_cmd),
        .o_result          (w_result),
        .o_sequence_number (w_seq)
    );

    // A new command loads the result register; otherwise a taken command empties it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_result.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_result.emit) begin
            r_command_code    <= w_result.code;
            r_sequence_number <= w_seq;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_command_code    = r_command_code;
    assign o_sequence_number = r_sequence_number;

endmodule

@@ hdl/bdp_checker.sv @@
// Port-level checker for the button double-press command decoder, with its bind.
// Depends only on the top level's ports.
module bdp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [2:0]  o_command_code,
    input logic [31:0] o_sequence_number
);
    logic        r_seen;
    logic [31:0] r_prev_seq;
    logic [31:0] w_expect;

    assign w_expect = r_seen ? (r_prev_seq + 32'd1) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen     <= 1'b0;
            r_prev_seq <= 32'd0;
        end else if (o_valid && i_ready) begin
            r_seen     <= 1'b1;
            r_prev_seq <= o_sequence_number;
        end
    end

    // Commands are numbered from zero after reset without gaps.
    a_seq_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_sequence_number == w_expect)
        else $error("sequence number out of order");

    // Only the seven defined command codes are ever shown.
    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_command_code <= 3'd6)
        else $error("undefined command code");

    // Reset leaves no command pending at the output.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // A stalled command stays offered.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_sequence_number))
        else $error("stalled command dropped");

endmodule

bind button_double_press_command_fsm bdp_checker u_bdp_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_valid           (o_valid),
    .i_ready           (i_ready),
    .o_command_code    (o_command_code),
    .o_sequence_number (o_sequence_number)
);
